>>> hw/rtl/emr_pkg.sv
`default_nettype none

package emr_pkg;

	// request kind carried on the slave-side tuser
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef enum logic [17:0] {
		S_IDLE = 18'b00_0000_0000_0000_0001,
		S_A2   = 18'b00_0000_0000_0000_0010,
		S_B2   = 18'b00_0000_0000_0000_0100,
		S_AB   = 18'b00_0000_0000_0000_1000,
		S_T3   = 18'b00_0000_0000_0001_0000,
		S_T3W  = 18'b00_0000_0000_0010_0000,
		S_R1X  = 18'b00_0000_0000_0100_0000,
		S_R1Y  = 18'b00_0000_0000_1000_0000,
		S_R1C  = 18'b00_0000_0001_0000_0000,
		S_R2X  = 18'b00_0000_0010_0000_0000,
		S_R2Y  = 18'b00_0000_0100_0000_0000,
		S_R2C  = 18'b00_0000_1000_0000_0000,
		S_M1   = 18'b00_0001_0000_0000_0000,
		S_M2   = 18'b00_0010_0000_0000_0000,
		S_M3   = 18'b00_0100_0000_0000_0000,
		S_M4   = 18'b00_1000_0000_0000_0000,
		S_M5   = 18'b01_0000_0000_0000_0000,
		S_EMIT = 18'b10_0000_0000_0000_0000
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ellipse_midpoint_raster.sv
`default_nettype none

// Channel   Dir  tdata (low bit up)                     tuser           tlast
// s_*       in   center_x, center_y, semi_a, semi_b     kind            -
// m_*       out  pixel_x, pixel_y                       curve_done      last_of_point
//
// One shared multiplier (registered product) runs under a one-hot sequencer.
// Start request: a^2, b^2, 2ab, (2ab)^2. Advance request: region tests, the
// midpoint products (region 2 tests again on a region change), four pixels;
// on a finished curve, just a curve_done beat. s_tready is high only in idle.
// Output stalls hold the sequencer in its emit step; one result register sits
// on the master side. Reset leaves the block idle with the curve finished.

module ellipse_midpoint_raster
	import emr_pkg::*;
#(
	parameter int COORD_BITS = 11
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       s_tvalid,
	output      logic                                       s_tready,
	// center_x, center_y, semi_a, semi_b
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]          s_tdata,
	// kind
	input  wire logic                                       s_tuser,
	output      logic                                       m_tvalid,
	input  wire logic                                       m_tready,
	// pixel_x, pixel_y
	output      logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]      m_tdata,
	// curve_done
	output      logic                                       m_tuser,
	output      logic                                       m_tlast
);

	localparam int C     = COORD_BITS;
	localparam int PW    = C + 1;
	localparam int OW    = C + 2;
	localparam int MW    = 2 * C + 2;
	localparam int ACC_W = 2 * MW;

	state_t state_q;

	logic [C-1:0]     cx_q, cy_q, a_q, b_q;
	logic [PW-1:0]    x_q, y_q;
	logic             r2_q, fin_q, done_q, dec_q;
	logic [1:0]       idx_q;
	logic [2*C-1:0]   a2_q, b2_q;
	logic [ACC_W-1:0] t3sq_q, acc_q, prod_q;
	logic [OW-1:0]    px_q, py_q;
	logic             last_q, user_q, out_valid_q;

	logic [MW-1:0]    op_a, op_b;
	logic [PW-1:0]    x_inc, y_inc, m_x, m_y, two_a, two_b;
	logic [OW-1:0]    cx_e, cy_e, x_e, y_e;
	logic             out_free, r1_pass, r2_pass, mid_ge;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		m_tdata = '0;
		m_tdata[OW-1:0]    = px_q;
		m_tdata[2*OW-1:OW] = py_q;
	end

	assign x_inc = x_q + PW'(1);
	assign y_inc = y_q + PW'(1);
	assign m_x   = (x_q == '0) ? PW'(1) : ((x_q << 1) - PW'(1));
	assign m_y   = (y_q == '0) ? PW'(1) : ((y_q << 1) - PW'(1));
	assign two_a = {a_q, 1'b0};
	assign two_b = {b_q, 1'b0};

	assign cx_e = {2'b00, cx_q};
	assign cy_e = {2'b00, cy_q};
	assign x_e  = {1'b0, x_q};
	assign y_e  = {1'b0, y_q};

	assign r1_pass = (x_q <= {1'b0, a_q}) && (acc_q <= prod_q);
	assign r2_pass = (y_q <= {1'b0, b_q}) && (acc_q >= prod_q);
	assign mid_ge  = ({1'b0, acc_q} + {1'b0, prod_q}) >= {1'b0, t3sq_q};

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_A2: begin
				op_a = MW'(a_q);
				op_b = MW'(a_q);
			end
			S_B2: begin
				op_a = MW'(b_q);
				op_b = MW'(b_q);
			end
			S_AB: begin
				op_a = MW'(two_a);
				op_b = MW'(b_q);
			end
			S_T3, S_M2, S_M4: begin
				op_a = prod_q[MW-1:0];
				op_b = prod_q[MW-1:0];
			end
			S_R1X, S_R2X: begin
				op_a = MW'(x_q);
				op_b = MW'(b2_q);
			end
			S_R1Y, S_R2Y: begin
				op_a = MW'(y_q);
				op_b = MW'(a2_q);
			end
			S_M1: begin
				op_a = r2_q ? MW'(b_q) : MW'(two_b);
				op_b = r2_q ? MW'(m_x) : MW'(x_inc);
			end
			S_M3: begin
				op_a = r2_q ? MW'(two_a) : MW'(a_q);
				op_b = r2_q ? MW'(y_inc) : MW'(m_y);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (state_q == S_B2) begin
			a2_q <= prod_q[2*C-1:0];
		end
		if (state_q == S_AB) begin
			b2_q <= prod_q[2*C-1:0];
		end
		if (state_q == S_T3W) begin
			t3sq_q <= prod_q;
		end
		if (state_q == S_R1Y || state_q == S_R2Y || state_q == S_M3) begin
			acc_q <= prod_q;
		end
		if (state_q == S_M5) begin
			dec_q <= mid_ge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cx_q        <= '0;
			cy_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			r2_q        <= 1'b0;
			fin_q       <= 1'b1;
			done_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			last_q      <= 1'b0;
			user_q      <= 1'b0;
		end else begin
			// the emit step reloads the result register itself
			if (m_tvalid && m_tready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == KIND_START) begin
							cx_q    <= s_tdata[C-1:0];
							cy_q    <= s_tdata[2*C-1:C];
							a_q     <= s_tdata[3*C-1:2*C];
							b_q     <= s_tdata[4*C-1:3*C];
							x_q     <= '0;
							y_q     <= {1'b0, s_tdata[4*C-1:3*C]};
							r2_q    <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= S_A2;
						end else if (fin_q) begin
							done_q  <= 1'b1;
							state_q <= S_EMIT;
						end else if (r2_q) begin
							state_q <= S_R2X;
						end else begin
							state_q <= S_R1X;
						end
					end
				end
				S_A2:  state_q <= S_B2;
				S_B2:  state_q <= S_AB;
				S_AB:  state_q <= S_T3;
				S_T3:  state_q <= S_T3W;
				S_T3W: state_q <= S_IDLE;
				S_R1X: state_q <= S_R1Y;
				S_R1Y: state_q <= S_R1C;
				S_R1C: begin
					if (r1_pass) begin
						state_q <= S_M1;
					end else begin
						// switch to region 2 and test it in this same request
						r2_q    <= 1'b1;
						x_q     <= {1'b0, a_q};
						y_q     <= '0;
						state_q <= S_R2X;
					end
				end
				S_R2X: state_q <= S_R2Y;
				S_R2Y: state_q <= S_R2C;
				S_R2C: begin
					if (r2_pass) begin
						state_q <= S_M1;
					end else begin
						fin_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: begin
					done_q  <= 1'b0;
					idx_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (done_q) begin
							px_q    <= '0;
							py_q    <= '0;
							last_q  <= 1'b0;
							user_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							user_q <= 1'b0;
							last_q <= (idx_q == 2'd3);
							px_q   <= idx_q[0] ? (cx_e - x_e) : (cx_e + x_e);
							py_q   <= idx_q[1] ? (cy_e - y_e) : (cy_e + y_e);
							idx_q  <= idx_q + 2'd1;
							if (idx_q == 2'd3) begin
								// step the point after its fourth pixel
								if (r2_q) begin
									y_q <= y_inc;
									if (dec_q && x_q != '0) begin
										x_q <= x_q - PW'(1);
									end
								end else begin
									x_q <= x_inc;
									if (dec_q && y_q != '0) begin
										y_q <= y_q - PW'(1);
									end
								end
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
